>>> hw/rtl/spt_pkg.sv
// Shared types and constants for the stable sorted priority table.
// No dependencies; imported by every module of the block.
package spt_pkg;

  // Table size and key width
  localparam int DEPTH    = 32;
  localparam int KEY_BITS = 16;
  localparam int ID_BITS  = 16;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  // Owner count limit
  localparam logic [15:0] OWNER_MAX = 16'hFFFF;

  // Input action codes
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_READ   = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

  // One stored record
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [ID_BITS-1:0]  id;
  } cell_data_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic             ins;       // insert new_data at its sorted place
    logic             rot;       // rotate the held records one place toward cell 0
    cell_data_t       new_data;
    logic [CNT_W-1:0] held;      // records held now
    logic [IDX_W-1:0] tail;      // position of the last held record
  } cell_ctl_t;

endpackage

>>> hw/rtl/spt_cell.sv
// One cell of the sorted record chain: holds one record and trades it with
// its neighbors on insert and rotate. Depends on spt_pkg.
module spt_cell (
  input  logic                       clk,
  input  spt_pkg::cell_ctl_t         ctl,
  input  logic [spt_pkg::IDX_W-1:0]  pos,
  input  spt_pkg::cell_data_t        prev_data,
  input  logic                       prev_valid,
  input  logic                       prev_occ,
  input  spt_pkg::cell_data_t        next_data,
  input  spt_pkg::cell_data_t        head_data,
  output spt_pkg::cell_data_t        data,
  output logic                       valid,
  output logic                       occ
);
  import spt_pkg::*;

  // Mark cells at or past the insertion point: empty, or key strictly greater
  assign valid = CNT_W'(pos) < ctl.held;
  assign occ   = !valid || (data.key > ctl.new_data.key);

  // Load new record, shift from left neighbor, or rotate from right
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (occ && !prev_occ) begin
        data <= ctl.new_data;
      end else if (occ && prev_valid) begin
        data <= prev_data;
      end
    end else if (ctl.rot) begin
      if (pos == ctl.tail) begin
        data <= head_data;
      end else if (pos < ctl.tail) begin
        data <= next_data;
      end
    end
  end

endmodule

>>> hw/rtl/spt_chain.sv
// Row of DEPTH record cells wired neighbor to neighbor; cell 0 is the head.
// Depends on spt_pkg and spt_cell.
module spt_chain (
  input  logic                clk,
  input  spt_pkg::cell_ctl_t  ctl,
  output spt_pkg::cell_data_t head
);
  import spt_pkg::*;

  cell_data_t cdata [DEPTH];
  logic       cvalid [DEPTH];
  logic       cocc [DEPTH];

  assign head = cdata[0];

  // Build the row
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    cell_data_t pd;
    cell_data_t nd;
    logic       pv;
    logic       po;

    if (g == 0) begin : g_first
      assign pd = ctl.new_data;
      assign pv = 1'b0;
      assign po = 1'b0;
    end else begin : g_mid
      assign pd = cdata[g-1];
      assign pv = cvalid[g-1];
      assign po = cocc[g-1];
    end

    if (g == DEPTH - 1) begin : g_end
      assign nd = cdata[0];
    end else begin : g_nxt
      assign nd = cdata[g+1];
    end

    spt_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (IDX_W'(g)),
      .prev_data  (pd),
      .prev_valid (pv),
      .prev_occ   (po),
      .next_data  (nd),
      .head_data  (cdata[0]),
      .data       (cdata[g]),
      .valid      (cvalid[g]),
      .occ        (cocc[g])
    );
  end

endmodule

>>> hw/rtl/stable_sorted_priority_table.sv
// Channel | dir | handshake            | payload
// in      | in  | in_valid / in_stall  | action patient_id health batch_last new_trainers
// out     | out | out_valid / out_stall| status has_entry entry_id entry_health
//         |     |                      | entry_index last entry_count trainer_count
//
// Insert, clear and other actions give a single result; an insert into a non-full
// table puts its record in its sorted place in the cell row on acceptance.
// A read-out of n records emits them in order after acceptance: the row rotates one
// place per emitted record, so it is back in order at the end. No item is
// accepted meanwhile. Reset is synchronous and empties the table at once.
// Output stall holds the result register and, through it, the read-out.
// Top level of the stable sorted priority table. Depends on spt_pkg, spt_chain.
module stable_sorted_priority_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [15:0] patient_id,
  input  logic [15:0] health,
  input  logic        batch_last,
  input  logic [15:0] new_trainers,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic        has_entry,
  output logic [15:0] entry_id,
  output logic [15:0] entry_health,
  output logic [4:0]  entry_index,
  output logic        last,
  output logic [5:0]  entry_count,
  output logic [15:0] trainer_count
);
  import spt_pkg::*;

  logic [CNT_W-1:0] held;
  logic [CNT_W-1:0] held_next;
  logic [15:0]      owners;
  logic [15:0]      owners_next;
  logic             busy;
  logic [IDX_W-1:0] rd_idx;

  logic             out_load;
  logic             in_acc;
  logic             full;
  logic             is_ins;
  logic             is_read;
  logic             rd_last;
  logic             emit;
  logic [16:0]      owner_sum;
  cell_ctl_t        ctl;
  cell_data_t       head;

  // Handshake
  assign out_load = !out_valid || !out_stall;
  assign in_stall = busy || !out_load;
  assign in_acc   = in_valid && !in_stall;

  assign full    = held == CNT_W'(DEPTH);
  assign is_ins  = action == ACT_INSERT;
  assign is_read = action == ACT_READ;
  assign rd_last = rd_idx == ctl.tail;

  // Next count and saturating owner total
  assign owner_sum = {1'b0, owners} + {1'b0, new_trainers};
  always_comb begin
    held_next   = held;
    owners_next = owners;
    if (in_acc) begin
      case (action)
        ACT_INSERT: begin
          if (!full) begin
            held_next = held + CNT_W'(1);
          end
          if (batch_last) begin
            owners_next = owner_sum[16] ? OWNER_MAX : owner_sum[15:0];
          end
        end
        ACT_CLEAR: held_next = '0;
        default:   held_next = held;
      endcase
    end
  end

  // Drive the cell row
  always_comb begin
    ctl.ins         = in_acc && is_ins && !full;
    ctl.rot         = busy && out_load;
    ctl.new_data.key = KEY_BITS'(health);
    ctl.new_data.id  = ID_BITS'(patient_id);
    ctl.held        = held;
    ctl.tail        = IDX_W'(held - CNT_W'(1));
  end

  spt_chain u_chain (
    .clk  (clk),
    .ctl  (ctl),
    .head (head)
  );

  assign emit = busy || (in_acc && !(is_read && held != '0));

  // Sequencer state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      owners    <= '0;
      busy      <= 1'b0;
      rd_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      held   <= held_next;
      owners <= owners_next;
      // start a read-out of a non-empty table
      if (in_acc && is_read && held != '0) begin
        busy   <= 1'b1;
        rd_idx <= '0;
      end else if (busy && out_load) begin
        rd_idx <= rd_idx + IDX_W'(1);
        if (rd_last) begin
          busy <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid <= emit;
        if (busy) begin
          status        <= 1'b0;
          has_entry     <= 1'b1;
          entry_id      <= 16'(head.id);
          entry_health  <= 16'(head.key);
          entry_index   <= 5'(rd_idx);
          last          <= rd_last;
          entry_count   <= 6'(held);
          trainer_count <= owners;
        end else begin
          status        <= is_ins && full;
          has_entry     <= 1'b0;
          entry_id      <= '0;
          entry_health  <= '0;
          entry_index   <= '0;
          last          <= 1'b1;
          entry_count   <= 6'(held_next);
          trainer_count <= owners_next;
        end
      end
    end
  end

endmodule

>>> hw/rtl/spt_checker.sv
// Port-level checks for the stable sorted priority table, bound to the top.
// Depends on spt_pkg and stable_sorted_priority_table.
module spt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        status,
  input logic        has_entry,
  input logic [15:0] entry_id,
  input logic [15:0] entry_health,
  input logic [4:0]  entry_index,
  input logic        last,
  input logic [5:0]  entry_count
);
  import spt_pkg::*;

  // Results without a record carry zero entry fields
  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_entry) |-> (entry_id == 16'd0 && entry_health == 16'd0
                                   && entry_index == 5'd0))
    else $error("entry fields not zero on a result without a record");

  // A dropped insert is a lone result without a record
  a_drop_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (!has_entry && last &&
                               entry_count == 6'(DEPTH)))
    else $error("dropped insert result malformed");

  // Hold the input while a read-out result other than the last is pending
  a_readout_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && has_entry && !last) |-> in_stall)
    else $error("item taken during a read-out");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(entry_id) &&
                                  $stable(entry_count) && $stable(last)))
    else $error("stalled result changed");

endmodule

bind stable_sorted_priority_table spt_checker u_spt_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .has_entry    (has_entry),
  .entry_id     (entry_id),
  .entry_health (entry_health),
  .entry_index  (entry_index),
  .last         (last),
  .entry_count  (entry_count)
);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for stable_sorted_priority_table: directed and random items
// with random idling on both channels. Depends on spt_pkg and the block's RTL.
module tb;
  import spt_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;     // unused action code
  localparam int         ITEM_GOAL = 380;
  localparam int         SEG_LEN   = 40;
  localparam int         IDLE_LIMIT = 4000;
  localparam int         TAIL_CYCLES = 16;

  typedef enum int {SEG_FILL, SEG_MIXED, SEG_CHURN} seg_kind_t;

  // Predicts the table contents and owner total and checks every result item
  class priority_scoreboard;
    typedef struct {
      logic        status;
      logic        has;
      logic [15:0] id;
      logic [15:0] key;
      logic [4:0]  idx;
      logic        last;
      logic [5:0]  count;
      logic [15:0] owners;
    } table_result_t;

    logic [KEY_BITS-1:0] key_row[DEPTH];
    logic [ID_BITS-1:0]  id_row[DEPTH];
    int                  held;
    logic [15:0]         owners;
    table_result_t       expected_q[$];
    int                  errors;

    function new();
      held   = 0;
      owners = '0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    function void push(logic st, logic has, logic [15:0] id, logic [15:0] key,
                       logic [4:0] idx, logic last);
      table_result_t r;
      r.status = st;
      r.has    = has;
      r.id     = id;
      r.key    = key;
      r.idx    = idx;
      r.last   = last;
      r.count  = 6'(held);
      r.owners = owners;
      expected_q.push_back(r);
    endfunction

    // Update the predicted table for one accepted item and queue its results
    function void note_item(logic [1:0] act, logic [15:0] pid, logic [15:0] health_in,
                            logic blast, logic [15:0] added);
      int                  pos;
      logic                st;
      logic [16:0]         sum;
      logic [KEY_BITS-1:0] key;
      key = health_in[KEY_BITS-1:0];
      case (act)
        ACT_INSERT: begin
          st = 1'b0;
          if (held >= DEPTH) begin
            st = 1'b1;
          end else begin
            // slide larger keys up; equal keys stay ahead of the new record
            pos = held;
            while (pos > 0 && key_row[pos-1] > key) begin
              key_row[pos] = key_row[pos-1];
              id_row[pos]  = id_row[pos-1];
              pos--;
            end
            key_row[pos] = key;
            id_row[pos]  = pid;
            held++;
          end
          if (blast) begin
            sum    = {1'b0, owners} + {1'b0, added};
            owners = sum[16] ? OWNER_MAX : sum[15:0];
          end
          push(st, 1'b0, '0, '0, '0, 1'b1);
        end
        ACT_READ: begin
          if (held == 0) begin
            push(1'b0, 1'b0, '0, '0, '0, 1'b1);
          end else begin
            for (int i = 0; i < held; i++)
              push(1'b0, 1'b1, 16'(id_row[i]), 16'(key_row[i]), 5'(i), i == held - 1);
          end
        end
        ACT_CLEAR: begin
          held = 0;
          push(1'b0, 1'b0, '0, '0, '0, 1'b1);
        end
        default: begin
          push(1'b0, 1'b0, '0, '0, '0, 1'b1);
        end
      endcase
    endfunction

    task check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("%s got %h, want %h", name, got, want));
    endtask

    task check_result(logic st, logic has, logic [15:0] id, logic [15:0] key,
                      logic [4:0] idx, logic last, logic [5:0] count,
                      logic [15:0] owner_cnt);
      table_result_t want;
      if (expected_q.size() == 0) begin
        report("result item with nothing expected");
      end else begin
        want = expected_q.pop_front();
        check_field("status", 16'(st), 16'(want.status));
        check_field("has_entry", 16'(has), 16'(want.has));
        check_field("entry_id", id, want.id);
        check_field("entry_health", key, want.key);
        check_field("entry_index", 16'(idx), 16'(want.idx));
        check_field("last", 16'(last), 16'(want.last));
        check_field("entry_count", 16'(count), 16'(want.count));
        check_field("trainer_count", owner_cnt, want.owners);
      end
    endtask

    task flag_leftovers();
      if (expected_q.size() != 0)
        report($sformatf("%0d result items never arrived", expected_q.size()));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  action;
  logic [15:0] patient_id;
  logic [15:0] health;
  logic        batch_last;
  logic [15:0] new_trainers;
  logic        out_valid;
  logic        out_stall;
  logic        status;
  logic        has_entry;
  logic [15:0] entry_id;
  logic [15:0] entry_health;
  logic [4:0]  entry_index;
  logic        last;
  logic [5:0]  entry_count;
  logic [15:0] trainer_count;

  priority_scoreboard sb = new();
  bit                 in_quiet;
  bit                 out_quiet;
  int                 stall_left;
  int                 idle_cycles;

  stable_sorted_priority_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .patient_id(patient_id), .health(health),
    .batch_last(batch_last), .new_trainers(new_trainers),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .has_entry(has_entry), .entry_id(entry_id),
    .entry_health(entry_health), .entry_index(entry_index), .last(last),
    .entry_count(entry_count), .trainer_count(trainer_count)
  );

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one; none in quiet stretches
  function int pick_gap(bit quiet);
    int r;
    if (quiet)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Drive the output stall at random
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap(out_quiet);
    end
  end

  // Check each accepted result item
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(status, has_entry, entry_id, entry_health, entry_index, last,
                      entry_count, trainer_count);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("stable_sorted_priority_table test failed");
        $finish;
      end
    end
  end

  // Offer one item after a random gap and hold it until accepted
  task send_item(logic [1:0] act, logic [15:0] pid, logic [15:0] key, logic blast,
                 logic [15:0] added);
    int gap;
    gap = pick_gap(in_quiet);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    action       <= act;
    patient_id   <= pid;
    health       <= key;
    batch_last   <= blast;
    new_trainers <= added;
    do @(posedge clk); while (in_stall);
    sb.note_item(act, pid, key, blast, added);
  endtask

  // Pick a key that often ties with stored ones
  function logic [15:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35)
      return 16'($urandom_range(0, 3));
    if (r < 50)
      return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
    if (r < 60)
      return 16'($urandom_range(16'h7FFE, 16'h8001));
    return 16'($urandom);
  endfunction

  task random_item(seg_kind_t kind);
    int          r;
    logic [1:0]  act;
    logic        blast;
    logic [15:0] added;
    r = $urandom_range(0, 99);
    case (kind)
      SEG_FILL:  act = (r < 90) ? ACT_INSERT : (r < 96) ? ACT_READ :
                       (r < 98) ? ACT_SPARE : ACT_CLEAR;
      SEG_MIXED: act = (r < 60) ? ACT_INSERT : (r < 85) ? ACT_READ :
                       (r < 93) ? ACT_CLEAR : ACT_SPARE;
      default:   act = (r < 45) ? ACT_INSERT : (r < 70) ? ACT_READ :
                       (r < 90) ? ACT_CLEAR : ACT_SPARE;
    endcase
    blast = ($urandom_range(0, 2) == 0);
    // keep the owner total well below saturation until the final items
    if (act == ACT_INSERT && blast)
      added = 16'($urandom_range(0, 300));
    else
      added = 16'($urandom);
    send_item(act, 16'($urandom), pick_key(), blast, added);
  endtask

  initial begin
    int sent;
    int seg;
    rst          = 1'b1;
    in_valid     = 1'b0;
    action       = ACT_INSERT;
    patient_id   = '0;
    health       = '0;
    batch_last   = 1'b0;
    new_trainers = '0;
    out_stall    = 1'b0;
    stall_left   = 0;
    idle_cycles  = 0;
    in_quiet     = 1'b0;
    out_quiet    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, unused action, key extremes, ties, ignored batch marks
    send_item(ACT_READ, 16'h0000, 16'h0000, 1'b0, 16'h0000);
    send_item(ACT_CLEAR, 16'h0000, 16'h0000, 1'b0, 16'h0000);
    send_item(ACT_SPARE, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF);
    send_item(ACT_INSERT, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0005);
    send_item(ACT_INSERT, 16'h0000, 16'h0000, 1'b0, 16'hFFFF);
    send_item(ACT_INSERT, 16'h1234, 16'h8000, 1'b0, 16'h0000);
    send_item(ACT_INSERT, 16'h5678, 16'h8000, 1'b1, 16'h0000);
    send_item(ACT_INSERT, 16'h9ABC, 16'h8000, 1'b0, 16'h0000);
    send_item(ACT_INSERT, 16'hAAAA, 16'h0000, 1'b1, 16'h0100);
    send_item(ACT_INSERT, 16'h5555, 16'hFFFF, 1'b0, 16'h0000);
    send_item(ACT_INSERT, 16'h0F0F, 16'h7FFF, 1'b0, 16'h0000);
    send_item(ACT_READ, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF);
    send_item(ACT_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF);
    send_item(ACT_READ, 16'h0000, 16'h0000, 1'b0, 16'h0000);
    send_item(ACT_INSERT, 16'h00FF, 16'h0001, 1'b0, 16'h0000);
    send_item(ACT_READ, 16'h0000, 16'h0000, 1'b0, 16'h0000);

    // Random: segments that fill the table, mix actions, or churn it
    sent = 0;
    seg  = 0;
    while (sent < ITEM_GOAL) begin
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < SEG_LEN && sent < ITEM_GOAL; i++) begin
        random_item(seg_kind_t'(seg % 3));
        sent++;
      end
      seg++;
    end

    // Saturate the owner count, then read back
    in_quiet  = 1'b0;
    out_quiet = 1'b0;
    send_item(ACT_INSERT, 16'($urandom), 16'hFFFF, 1'b1, 16'hFFFF);
    send_item(ACT_INSERT, 16'($urandom), 16'h0000, 1'b1, 16'hFFFF);
    send_item(ACT_READ, 16'h0000, 16'h0000, 1'b0, 16'h0000);

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.flag_leftovers();
    if (sb.errors == 0)
      $display("stable_sorted_priority_table test passed");
    else
      $display("stable_sorted_priority_table test failed");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/spt_pkg.sv
hw/rtl/spt_cell.sv
hw/rtl/spt_chain.sv
hw/rtl/stable_sorted_priority_table.sv
hw/rtl/spt_checker.sv
tb/sv/tb.sv
